// ===== sv/shss_pkg.sv =====
// Package for the hash-chain secret store: types, constants and SHA-256 helpers.
package shss_pkg;

  localparam int INDEX_BITS = 48;
  localparam int SLOT_COUNT = INDEX_BITS + 1;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int BIT_W = $clog2(INDEX_BITS + 1);
  localparam int CNT_W = 6;
  localparam int SECRET_W = 256;

  typedef struct packed {
    logic [63:0] secret_word3;
    logic [63:0] secret_word2;
    logic [63:0] secret_word1;
    logic [63:0] secret_word0;
    logic [47:0] index;
    logic        mode;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  valid_count;
    logic [63:0] out_word3;
    logic [63:0] out_word2;
    logic [63:0] out_word1;
    logic [63:0] out_word0;
    logic        ok;
  } out_item_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DERIVE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_LOAD,
    ST_BIT,
    ST_HASH,
    ST_CHECK,
    ST_COMMIT,
    ST_DONE
  } state_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  localparam logic [255:0] START_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Trailing-zero count of the masked index; all zero gives INDEX_BITS.
  function automatic logic [BIT_W-1:0] tz_count(input logic [INDEX_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = BIT_W'(INDEX_BITS);
    for (int i = INDEX_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/shss_ram.sv =====
// Generic single-port RAM with registered read.
module shss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/shss_hash.sv =====
// Iterative SHA-256 core: one round per cycle on a single padded 32-byte block.
module shss_hash (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [shss_pkg::SECRET_W-1:0]   din,
  output logic                            busy,
  output logic [shss_pkg::SECRET_W-1:0]   dout
);

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [6:0]  rnd_r;
  logic        busy_r;
  logic [31:0] t1, t2, s0, s1, wnew;
  logic [31:0] hv [8];

  function automatic logic [31:0] START_WORD(input int i);
    return shss_pkg::START_H[255 - 32*i -: 32];
  endfunction

  // Message bytes are in big-endian word order for SHA-256.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hv[i] = START_WORD(i);
    end
  end

  always_comb begin
    s0 = shss_pkg::rotr(w_r[1], 7) ^ shss_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = shss_pkg::rotr(w_r[14], 17) ^ shss_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    for (int i = 0; i < 15; i++) begin
      w_nxt[i] = w_r[i+1];
    end
    w_nxt[15] = wnew;
    t1 = h_r + (shss_pkg::rotr(e_r, 6) ^ shss_pkg::rotr(e_r, 11) ^ shss_pkg::rotr(e_r, 25))
         + ((e_r & f_r) ^ (~e_r & g_r)) + shss_pkg::round_k(rnd_r[5:0]) + w_r[0];
    t2 = (shss_pkg::rotr(a_r, 2) ^ shss_pkg::rotr(a_r, 13) ^ shss_pkg::rotr(a_r, 22))
         + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      rnd_r  <= '0;
    end else if (busy_r) begin
      rnd_r <= rnd_r + 7'd1;
      if (rnd_r == 7'd63) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        w_r[i] <= {din[8*(4*i)+:8], din[8*(4*i+1)+:8], din[8*(4*i+2)+:8],
                   din[8*(4*i+3)+:8]};
      end
      w_r[8] <= 32'h80000000;
      for (int i = 9; i < 15; i++) begin
        w_r[i] <= '0;
      end
      w_r[15] <= 32'd256;
      a_r <= hv[0]; b_r <= hv[1]; c_r <= hv[2]; d_r <= hv[3];
      e_r <= hv[4]; f_r <= hv[5]; g_r <= hv[6]; h_r <= hv[7];
    end else if (busy_r) begin
      w_r <= w_nxt;
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
  end

  logic [31:0] fin [8];
  always_comb begin
    fin[0] = hv[0] + a_r; fin[1] = hv[1] + b_r; fin[2] = hv[2] + c_r; fin[3] = hv[3] + d_r;
    fin[4] = hv[4] + e_r; fin[5] = hv[5] + f_r; fin[6] = hv[6] + g_r; fin[7] = hv[7] + h_r;
    for (int i = 0; i < 8; i++) begin
      dout[8*(4*i)+:8]   = fin[i][31:24];
      dout[8*(4*i+1)+:8] = fin[i][23:16];
      dout[8*(4*i+2)+:8] = fin[i][15:8];
      dout[8*(4*i+3)+:8] = fin[i][7:0];
    end
  end

  assign busy = busy_r;

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rnd_r <= 7'd63) else $error("round counter overran");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && rnd_r == 7'd0) else $error("start did not begin a hash");
  a_done_fall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && rnd_r == 7'd63 && !start) |=> !busy_r) else $error("hash did not finish");

endmodule

// ===== sv/shachain_secret_store.sv =====
// Top level of the hash-chain secret store: slot memory, sequencer and output register.
//
// Operation: an insert or derive runs alone; in_stall stays high until its single result
// has been loaded into the output register. The block walks the slots one per step; each
// hash uses the one SHA-256 core for 64 rounds. An insert into slot s checks every valid
// lower slot; a derive scans the slots until a stored one reaches the index, then walks
// the index bits, with at most 48 hashes. No clearing pass is needed after reset.
module shachain_secret_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  shss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output shss_pkg::out_item_t out_data
);

  localparam int SW = shss_pkg::SLOT_W;
  localparam int BW = shss_pkg::BIT_W;
  localparam int IB = shss_pkg::INDEX_BITS;
  localparam int CNTW = shss_pkg::CNT_W;

  shss_pkg::state_t state_r, state_nxt;

  logic            mode_r;
  logic [IB-1:0]   idx_r;
  logic [255:0]    new_r;
  logic [SW-1:0]   tslot_r;
  logic [SW-1:0]   slot_r;
  logic [BW-1:0]   bit_r;
  logic [255:0]    acc_r;
  logic [IB-1:0]   kidx_r, tgt_r;
  logic [shss_pkg::SLOT_COUNT-1:0] valid_r;
  logic [SW-1:0]   high_r;
  logic            ok_r;
  logic            ov_r;
  shss_pkg::out_item_t od_r;

  logic            ram_we;
  logic [SW-1:0]   ram_addr;
  logic [255:0]    ram_sec;
  logic [IB-1:0]   ram_idx;

  logic            hash_start;
  logic            hash_busy;
  logic [255:0]    hash_din;
  logic [255:0]    hash_out;

  shss_ram #(.WIDTH(256), .DEPTH(shss_pkg::SLOT_COUNT)) u_sec (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(new_r), .rdata(ram_sec));
  shss_ram #(.WIDTH(IB), .DEPTH(shss_pkg::SLOT_COUNT)) u_idx (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(idx_r), .rdata(ram_idx));

  shss_hash u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .din(hash_din),
    .busy(hash_busy), .dout(hash_out));

  // Reach test: target equals source in every bit at or above the source's trailing zeros.
  logic [BW-1:0]   ktz;
  logic [IB-1:0]   rmask;
  logic            reach;
  logic            scan_end;
  logic            step_bit;
  always_comb begin
    ktz = shss_pkg::tz_count(kidx_r);
    rmask = (ktz >= BW'(IB)) ? '0 : ~((IB'(1) << ktz) - IB'(1));
    reach = ((tgt_r & rmask) == (kidx_r & rmask));
    scan_end = mode_r ? (slot_r >= high_r) || (32'(slot_r) >= shss_pkg::SLOT_COUNT)
                      : (slot_r >= tslot_r) || (slot_r >= high_r);
    step_bit = (bit_r != '0) && tgt_r[bit_r - BW'(1)] && !kidx_r[bit_r - BW'(1)];
  end

  // The hash starts from the accumulator with the current bit already flipped.
  always_comb begin
    hash_din = acc_r;
    if (bit_r != '0) begin
      hash_din[bit_r - BW'(1)] = ~acc_r[bit_r - BW'(1)];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shss_pkg::ST_IDLE:   if (in_valid) state_nxt = shss_pkg::ST_SCAN;
      shss_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = (!mode_r && ok_r) ? shss_pkg::ST_COMMIT : shss_pkg::ST_DONE;
        else if (valid_r[slot_r]) state_nxt = shss_pkg::ST_READ;
      end
      shss_pkg::ST_READ:   state_nxt = shss_pkg::ST_LOAD;
      shss_pkg::ST_LOAD:   state_nxt = shss_pkg::ST_BIT;
      shss_pkg::ST_BIT: begin
        if (!reach) state_nxt = mode_r ? shss_pkg::ST_SCAN : shss_pkg::ST_DONE;
        else if (bit_r == '0) state_nxt = shss_pkg::ST_CHECK;
        else if (step_bit) state_nxt = shss_pkg::ST_HASH;
      end
      shss_pkg::ST_HASH:   if (!hash_busy && !hash_start) state_nxt = shss_pkg::ST_BIT;
      shss_pkg::ST_CHECK: begin
        if (mode_r) state_nxt = shss_pkg::ST_DONE;
        else if (acc_r != ram_sec) state_nxt = shss_pkg::ST_DONE;
        else state_nxt = shss_pkg::ST_SCAN;
      end
      shss_pkg::ST_COMMIT: state_nxt = shss_pkg::ST_DONE;
      shss_pkg::ST_DONE:   if (!ov_r || !out_stall) state_nxt = shss_pkg::ST_IDLE;
      default:             state_nxt = shss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = (state_r == shss_pkg::ST_COMMIT);
    ram_addr = (state_r == shss_pkg::ST_COMMIT) ? tslot_r : slot_r;
    hash_start = (state_r == shss_pkg::ST_BIT) && reach && step_bit;
    in_stall = (state_r != shss_pkg::ST_IDLE);
  end

  logic [IB-1:0] in_idx;
  logic [BW-1:0] in_tz;
  assign in_idx = in_data.index[IB-1:0];
  assign in_tz = shss_pkg::tz_count(in_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shss_pkg::ST_IDLE;
      valid_r <= '0;
      high_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == shss_pkg::ST_COMMIT) begin
        valid_r[tslot_r] <= 1'b1;
        if (tslot_r + SW'(1) > high_r) high_r <= tslot_r + SW'(1);
      end
      if (state_r == shss_pkg::ST_DONE && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  logic [CNTW-1:0] vcount;
  assign vcount = CNTW'($countones(valid_r));

  always_ff @(posedge clk) begin
    case (state_r)
      shss_pkg::ST_IDLE: begin
        mode_r  <= in_data.mode;
        idx_r   <= in_idx;
        new_r   <= {in_data.secret_word3, in_data.secret_word2, in_data.secret_word1,
                    in_data.secret_word0};
        tslot_r <= SW'(in_tz);
        slot_r  <= '0;
        ok_r    <= (in_data.mode == shss_pkg::MODE_INSERT);
      end
      shss_pkg::ST_SCAN: if (!scan_end && !valid_r[slot_r]) slot_r <= slot_r + SW'(1);
      shss_pkg::ST_LOAD: begin
        if (mode_r) begin
          acc_r <= ram_sec; kidx_r <= ram_idx; tgt_r <= idx_r;
          bit_r <= shss_pkg::tz_count(ram_idx);
        end else begin
          acc_r <= new_r; kidx_r <= idx_r; tgt_r <= ram_idx;
          bit_r <= shss_pkg::tz_count(idx_r);
        end
      end
      shss_pkg::ST_BIT: begin
        if (!reach) begin
          if (mode_r) slot_r <= slot_r + SW'(1);
          else ok_r <= 1'b0;
        end else if (bit_r != '0) begin
          bit_r <= bit_r - BW'(1);
          if (step_bit) acc_r[bit_r - BW'(1)] <= ~acc_r[bit_r - BW'(1)];
        end
      end
      shss_pkg::ST_HASH: if (!hash_busy && !hash_start) acc_r <= hash_out;
      shss_pkg::ST_CHECK: begin
        if (mode_r) ok_r <= 1'b1;
        else if (acc_r != ram_sec) ok_r <= 1'b0;
        else slot_r <= slot_r + SW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == shss_pkg::ST_DONE && (!ov_r || !out_stall)) begin
      od_r.ok <= ok_r;
      {od_r.out_word3, od_r.out_word2, od_r.out_word1, od_r.out_word0} <=
        (mode_r && ok_r) ? acc_r : '0;
      od_r.valid_count <= vcount;
    end
  end

  assign out_valid = ov_r;
  assign out_data = od_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != shss_pkg::ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_commit_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shss_pkg::ST_COMMIT) |=> valid_r[$past(tslot_r)]) else $error("slot not set");
  a_commit_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shss_pkg::ST_COMMIT) |-> (!mode_r && ok_r)) else $error("bad commit");

endmodule
